// ----- rtl/beep_pattern_sequencer_macros.svh -----
// Assertion macros shared by the beep pattern sequencer checkers.
`ifndef BEEP_PATTERN_SEQUENCER_MACROS_SVH
`define BEEP_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bps_pkg.sv -----
// Shared types and constants of the beep pattern sequencer.
package bps_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned CNT_W     = 2;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_CLICK    = 2'd1,
    MODE_INCOMING = 2'd2,
    MODE_SUCCESS  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_ON   = 4'd0,
    REG_NORMAL_GAP  = 4'd1,
    REG_SUCCESS_ON  = 4'd2,
    REG_SUCCESS_GAP = 4'd3
  } reg_idx_t;

  localparam logic [DUR_W-1:0] NORMAL_ON_RST   = 16'd50;
  localparam logic [DUR_W-1:0] NORMAL_GAP_RST  = 16'd50;
  localparam logic [DUR_W-1:0] SUCCESS_ON_RST  = 16'd100;
  localparam logic [DUR_W-1:0] SUCCESS_GAP_RST = 16'd80;

  // Pulse counts of the three patterns.
  localparam logic [CNT_W-1:0] CLICK_PULSES    = 2'd1;
  localparam logic [CNT_W-1:0] INCOMING_PULSES = 2'd3;
  localparam logic [CNT_W-1:0] SUCCESS_PULSES  = 2'd2;

  typedef struct packed {
    logic [DUR_W-1:0] normal_on;
    logic [DUR_W-1:0] normal_gap;
    logic [DUR_W-1:0] success_on;
    logic [DUR_W-1:0] success_gap;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] pulses_left;
    phase_t           phase_now;
    logic             buzzer_on;
  } result_t;

endpackage

// ----- rtl/bps_cfg_regs.sv -----
// Configuration register file of the beep pattern sequencer.
module bps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [bps_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [bps_pkg::DUR_W-1:0]     wr_data,
  output bps_pkg::cfg_t                 cfg
);
  import bps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_NORMAL_ON:   cfg_nxt.normal_on   = wr_data;
        REG_NORMAL_GAP:  cfg_nxt.normal_gap  = wr_data;
        REG_SUCCESS_ON:  cfg_nxt.success_on  = wr_data;
        REG_SUCCESS_GAP: cfg_nxt.success_gap = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_on   <= NORMAL_ON_RST;
      cfg_r.normal_gap  <= NORMAL_GAP_RST;
      cfg_r.success_on  <= SUCCESS_ON_RST;
      cfg_r.success_gap <= SUCCESS_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/bps_core.sv -----
// Pattern state machine and deadline datapath of the beep pattern sequencer.
module bps_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  bps_pkg::mode_t             mode,
  input  logic [bps_pkg::TIME_W-1:0] now_ms,
  input  bps_pkg::cfg_t              cfg,
  output bps_pkg::result_t           result
);
  import bps_pkg::*;

  phase_t            phase_r,    phase_nxt;
  logic [TIME_W-1:0] deadline_r, deadline_nxt;
  logic [CNT_W-1:0]  count_r,    count_nxt;
  logic              long_r,     long_nxt;
  logic              pin_r,      pin_nxt;

  logic [TIME_W-1:0] diff;
  logic              due;
  logic              start;
  logic              start_long;
  logic [CNT_W-1:0]  start_cnt;
  logic [CNT_W-1:0]  cnt_dec;
  logic              tone_long;
  logic [DUR_W-1:0]  dur;

  // A wrapping difference with the sign bit clear means the deadline is reached.
  assign diff    = now_ms - deadline_r;
  assign due     = (mode == MODE_TICK) && (phase_r != PH_IDLE) && !diff[TIME_W-1];
  assign cnt_dec = count_r - CNT_W'(1);

  always_comb begin
    start      = 1'b0;
    start_long = 1'b0;
    start_cnt  = CLICK_PULSES;
    case (mode)
      MODE_CLICK:    start = (phase_r == PH_IDLE);
      MODE_INCOMING: begin
        start     = 1'b1;
        start_cnt = INCOMING_PULSES;
      end
      MODE_SUCCESS:  begin
        start      = 1'b1;
        start_long = 1'b1;
        start_cnt  = SUCCESS_PULSES;
      end
      default: ;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (start) begin
      phase_nxt = PH_ON;
    end else if (due) begin
      case (phase_r)
        PH_ON:   phase_nxt = (cnt_dec == '0) ? PH_IDLE : PH_GAP;
        PH_GAP:  phase_nxt = PH_ON;
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Deadline, pulse count, tone and pin level. One adder serves every case.
  always_comb begin
    tone_long = start ? start_long : long_r;
    if (!start && due && (phase_r == PH_ON)) begin
      dur = tone_long ? cfg.success_gap : cfg.normal_gap;
    end else begin
      dur = tone_long ? cfg.success_on : cfg.normal_on;
    end

    deadline_nxt = deadline_r;
    count_nxt    = count_r;
    long_nxt     = long_r;
    pin_nxt      = pin_r;
    if (start) begin
      deadline_nxt = now_ms + TIME_W'(dur);
      count_nxt    = start_cnt;
      long_nxt     = start_long;
      pin_nxt      = 1'b1;
    end else if (due && (phase_r == PH_ON)) begin
      pin_nxt   = 1'b0;
      count_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        long_nxt = 1'b0;
      end else begin
        deadline_nxt = now_ms + TIME_W'(dur);
      end
    end else if (due) begin
      pin_nxt      = 1'b1;
      deadline_nxt = now_ms + TIME_W'(dur);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      deadline_r <= '0;
      count_r    <= '0;
      long_r     <= 1'b0;
      pin_r      <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      deadline_r <= deadline_nxt;
      count_r    <= count_nxt;
      long_r     <= long_nxt;
      pin_r      <= pin_nxt;
    end
  end

  // The result shows the state after the word has been applied.
  assign result.buzzer_on   = pin_nxt;
  assign result.phase_now   = phase_nxt;
  assign result.pulses_left = count_nxt;

endmodule

// ----- rtl/beep_pattern_sequencer.sv -----
// Top level of the beep pattern sequencer: input stage, state update, result stage.
//
//   channel   direction  payload                                   handshake
//   in_       slave      tuser = mode, tdata = now_ms              tvalid/tready
//   out_      master     tdata = buzzer_on, phase_now, pulses_left tvalid/tready
//   cfg_      slave      cfg_index, cfg_data                       cfg_valid/cfg_ready
//
// One word is accepted per clock cycle while out_tready stays high. A word is held
// in the input register and is then loaded into the result register, from which
// its result word shows on the out_ port.
// The state machine is updated as a word moves from the input register into
// the result register, so the next word always sees the updated state.
// Reset (rst_n low, synchronous) empties both stages, sets the registers to
// their default durations and puts the pattern state in idle with the pin low.
// A stall on the output side holds the result word; the input register still
// takes one more word, after which in_tready drops until out_tready returns.
module beep_pattern_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input words.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bps_pkg::TIME_W-1:0]          in_tdata,  // [31:0] now_ms
  input  logic [1:0]                          in_tuser,  // [1:0] mode
  // Result words.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bps_pkg::OUT_TDATA_W-1:0]     out_tdata, // [0] buzzer_on, [2:1] phase_now,
                                                         // [4:3] pulses_left, [7:5] zero
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bps_pkg::DUR_W-1:0]           cfg_data
);
  import bps_pkg::*;

  // Input register.
  logic              s1_valid_r, s1_valid_nxt;
  mode_t             s1_mode_r;
  logic [TIME_W-1:0] s1_now_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;

  logic              s1_adv;
  logic              in_acc;
  cfg_t              cfg;
  result_t           step_res;

  // The word in the input register moves on whenever the result register is
  // empty or is being emptied in this cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  bps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bps_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .mode    (s1_mode_r),
    .now_ms  (s1_now_r),
    .cfg     (cfg),
    .result  (step_res)
  );

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= mode_t'(in_tuser);
      s1_now_r  <= in_tdata;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.pulses_left, out_res_r.phase_now,
                       out_res_r.buzzer_on};

endmodule

// ----- rtl/bps_checker.sv -----
// Port-level checker of the beep pattern sequencer and its bind.
`include "beep_pattern_sequencer_macros.svh"

module bps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A stalled result word holds still.
  `BPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // Idle means pin low and no pulses left.
  `BPS_ASSERT_NOW(a_idle_quiet, clk, rst_n, out_tvalid && (out_tdata[2:1] == 2'd0), (out_tdata[0] == 1'b0) && (out_tdata[4:3] == 2'd0), "idle with pin high or pulses pending")

  // A pulse drives the pin high and always has a pulse left to count.
  `BPS_ASSERT_NOW(a_on_level, clk, rst_n, out_tvalid && (out_tdata[2:1] == 2'd1), (out_tdata[0] == 1'b1) && (out_tdata[4:3] != 2'd0), "pulse phase with pin low or count zero")

  // A gap keeps the pin low and still has pulses to come.
  `BPS_ASSERT_NOW(a_gap_level, clk, rst_n, out_tvalid && (out_tdata[2:1] == 2'd2), (out_tdata[0] == 1'b0) && (out_tdata[4:3] != 2'd0), "gap phase with pin high or count zero")

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
